>>> hdl/sha0_pkg.sv
`default_nettype none
package sha0_pkg;

  // Block geometry
  localparam int BlockWords = 16;
  localparam int DigestWords = 5;
  localparam int Rounds = 80;

  // Round constants
  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  // Round boundaries between the four round functions
  localparam logic [6:0] RND_LAST = 7'(Rounds - 1);
  localparam logic [6:0] RND_F1 = 7'd20;
  localparam logic [6:0] RND_F2 = 7'd40;
  localparam logic [6:0] RND_F3 = 7'd60;

  // Initial chaining value
  localparam logic [31:0] CHAIN_INIT [DigestWords] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'(DigestWords - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_INIT,
    S_ROUND,
    S_ADD,
    S_LENBLK,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    P_DATA,
    P_EXTRA,
    P_FINAL
  } phase_t;

  typedef struct packed {
    logic       byte_wr;
    logic       pad;
    logic       len_blk;
    logic       init_work;
    logic       round;
    logic       add_chain;
    logic       out_load;
    logic       chain_init;
    logic [6:0] rnd;
    logic [2:0] word_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_hi;
    logic out_free;
  } dp_stat_t;

  // Place one byte into a big-endian word at byte lane b (0 is the MSB lane)
  function automatic logic [31:0] place_byte(input logic [31:0] word,
                                             input logic [7:0] data,
                                             input logic [1:0] b);
    logic [31:0] res;
    case (b)
      2'd0: res = {data, 24'h0};
      2'd1: res = {word[31:24], data, word[15:0]};
      2'd2: res = {word[31:16], data, word[7:0]};
      2'd3: res = {word[31:8], data};
      default: res = word;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha0_ctrl.sv
`default_nettype none
module sha0_ctrl import sha0_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  input  wire dp_stat_t stat,
  output logic          in_stall,
  output ctrl_cmd_t     cmd
);

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       end_pend_r, end_pend_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       in_xfer;

  assign in_xfer = in_valid && (state_r == S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    end_pend_nxt = end_pend_r;
    rnd_nxt = rnd_r;
    widx_nxt = widx_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          phase_nxt = P_DATA;
          end_pend_nxt = in_data.end_of_message;
          if (in_data.byte_present && stat.pos_last) begin
            state_nxt = S_INIT;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        phase_nxt = stat.pos_hi ? P_EXTRA : P_FINAL;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        rnd_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        case (phase_r)
          P_DATA:  state_nxt = end_pend_r ? S_PAD : S_IDLE;
          P_EXTRA: state_nxt = S_LENBLK;
          P_FINAL: begin
            widx_nxt = '0;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LENBLK: begin
        phase_nxt = P_FINAL;
        state_nxt = S_INIT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == WORD_LAST) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    cmd.rnd = rnd_r;
    cmd.word_idx = widx_r;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:   cmd.byte_wr = in_xfer && in_data.byte_present;
      S_PAD:    cmd.pad = 1'b1;
      S_INIT:   cmd.init_work = 1'b1;
      S_ROUND:  cmd.round = 1'b1;
      S_ADD:    cmd.add_chain = 1'b1;
      S_LENBLK: cmd.len_blk = 1'b1;
      S_OUT: begin
        cmd.out_load = stat.out_free;
        cmd.chain_init = stat.out_free && (widx_r == WORD_LAST);
      end
      default: cmd = '0;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= P_DATA;
      end_pend_r <= 1'b0;
      rnd_r <= '0;
      widx_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      end_pend_r <= end_pend_nxt;
      rnd_r <= rnd_nxt;
      widx_r <= widx_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sha0_dpath.sv
`default_nettype none
module sha0_dpath import sha0_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctrl_cmd_t cmd,
  input  wire in_item_t  in_data,
  input  wire logic      out_stall,
  output dp_stat_t       stat,
  output logic           out_valid,
  output out_item_t      out_data
);

  logic [31:0] w_r [BlockWords];
  logic [31:0] w_nxt [BlockWords];
  logic [31:0] chain_r [DigestWords];
  logic [31:0] chain_nxt [DigestWords];
  logic [31:0] work_r [DigestWords];
  logic [31:0] work_nxt [DigestWords];
  logic [63:0] len_r, len_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic [5:0]  pos;
  logic [31:0] f, k, t;

  assign pos = len_r[8:3];
  assign stat.pos_last = (pos == POS_LAST);
  assign stat.pos_hi = (pos[5:3] == 3'b111);
  assign stat.out_free = !out_valid_r || !out_stall;

  // Block window: byte packing, padding, length block, and schedule shift during rounds
  always_comb begin
    w_nxt = w_r;
    if (cmd.byte_wr) begin
      w_nxt[pos[5:2]] = place_byte(w_r[pos[5:2]], in_data.data_byte, pos[1:0]);
    end else if (cmd.pad) begin
      for (int i = 0; i < BlockWords; i++) begin
        if (4'(i) > pos[5:2]) begin
          w_nxt[i] = '0;
        end
      end
      w_nxt[pos[5:2]] = place_byte(w_r[pos[5:2]], PAD_BYTE, pos[1:0]);
      if (!stat.pos_hi) begin
        w_nxt[BlockWords-2] = len_r[63:32];
        w_nxt[BlockWords-1] = len_r[31:0];
      end
    end else if (cmd.len_blk) begin
      for (int i = 0; i < BlockWords - 2; i++) begin
        w_nxt[i] = '0;
      end
      w_nxt[BlockWords-2] = len_r[63:32];
      w_nxt[BlockWords-1] = len_r[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[BlockWords-1] = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    end
  end

  // Round function and constant
  always_comb begin
    if (cmd.rnd < RND_F1) begin
      f = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      k = K0;
    end else if (cmd.rnd < RND_F2) begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
      k = K1;
    end else if (cmd.rnd < RND_F3) begin
      f = (work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) | (work_r[2] & work_r[3]);
      k = K2;
    end else begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
      k = K3;
    end
    t = {work_r[0][26:0], work_r[0][31:27]} + f + work_r[4] + k + w_r[0];
  end

  // Working variables and chaining value
  always_comb begin
    work_nxt = work_r;
    chain_nxt = chain_r;
    if (cmd.init_work) begin
      work_nxt = chain_r;
    end else if (cmd.round) begin
      work_nxt[0] = t;
      work_nxt[1] = work_r[0];
      work_nxt[2] = {work_r[1][1:0], work_r[1][31:2]};
      work_nxt[3] = work_r[2];
      work_nxt[4] = work_r[3];
    end
    if (cmd.add_chain) begin
      for (int i = 0; i < DigestWords; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end else if (cmd.chain_init) begin
      chain_nxt = CHAIN_INIT;
    end
  end

  // Message bit count, advanced a byte at a time and cleared with the chaining value
  always_comb begin
    len_nxt = len_r;
    if (cmd.byte_wr) begin
      len_nxt = {len_r[63:3] + 61'd1, 3'b000};
    end else if (cmd.chain_init) begin
      len_nxt = '0;
    end
  end

  // Result register: load a digest word, drop it once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.digest_word = chain_r[cmd.word_idx];
      out_data_nxt.word_number = cmd.word_idx;
      out_data_nxt.last_word = (cmd.word_idx == WORD_LAST);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= CHAIN_INIT;
      len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chain_r <= chain_nxt;
      len_r <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    work_r <= work_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire

>>> hdl/sha0_hash_engine.sv
`default_nettype none
// SHA-0 hash engine. Message bytes are taken one per transfer; a byte that
// neither completes a 64-byte block nor ends the message keeps in_stall low.
// The byte that completes a block starts a compression (load, 80 rounds of
// one shared round unit, chaining add), during which in_stall is high. An
// end transfer costs a padding step and one compression, or two compressions
// with a length-block step between when the last block has no room for the
// bit count; then the five digest words h0..h4 leave through a registered
// output, one per cycle when out_stall is low. After h4 is loaded the chaining
// value and bit count return to initial values and the next message may start.
module sha0_hash_engine import sha0_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  output logic          in_stall,
  output logic          out_valid,
  output out_item_t     out_data,
  input  wire logic     out_stall
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sha0_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sha0_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // An ending transfer keeps the block busy for padding and compression
  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.end_of_message) |=> in_stall)
    else $error("input taken right after end of message");

  // Digest words follow back to back once the previous one is transferred
  a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_word) |=> out_valid)
    else $error("gap between digest words");

  // Digest words come in order
  a_words_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_word) |=>
    (out_data.word_number == $past(out_data.word_number) + 3'd1))
    else $error("digest word out of order");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_sha0_hash_engine.sv
`default_nettype none
module tb_sha0_hash_engine;
  import sha0_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 100;
  localparam int DrainCycles = 200;

  // Known digests, h0 in the top word
  localparam logic [159:0] EMPTY_DIGEST = 160'hf96cea198ad1dd5617ac084a3d92c6107708c0ef;
  localparam logic [159:0] ABC_DIGEST = 160'h0164b8a914cd2a5e74c4f7ff082c4d97f1edf880;

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [31:0] HASH_START [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         byte_present;
    logic         end_of_message;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  typedef struct packed {
    logic         known;
    logic [159:0] digest;
  } digest_ref_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall = 1'b0;

  // Predictor state
  logic [31:0] hash_state [5];
  logic [31:0] msg_block [16];
  logic [63:0] bit_count;

  out_item_t   digest_words_due [$];
  digest_ref_t typed_digests [$];
  stim_row_t   directed_rows [$];

  int sender_idle_pct = 7;
  int recv_stall_pct = 62;
  int failures = 0;
  int item_count = 0;
  int idle_count = 0;
  int messages_done = 0;
  int extra_pad_blocks = 0;
  int words_checked = 0;
  int cycle_count = 0;

  sha0_hash_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run 80 rounds over the current block and fold into the chaining value
  function automatic void sha0_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 80; i++) w[i] = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = ROUND_K[0];
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = ROUND_K[1];
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = ROUND_K[2];
      end else begin
        f = b ^ c ^ d;
        k = ROUND_K[3];
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // Place a byte big-endian; lane 0 starts a fresh word
  function automatic void place_msg_byte(input logic [5:0] pos, input logic [7:0] val);
    case (pos[1:0])
      2'd0: msg_block[pos[5:2]] = {val, 24'h0};
      2'd1: msg_block[pos[5:2]][23:16] = val;
      2'd2: msg_block[pos[5:2]][15:8] = val;
      default: msg_block[pos[5:2]][7:0] = val;
    endcase
  endfunction

  // Absorb one accepted transfer; on end, pad, finish and queue the digest
  function automatic void sha0_absorb(input in_item_t it, input digest_ref_t typed);
    logic [5:0] pos;
    if (it.byte_present) begin
      pos = bit_count[8:3];
      place_msg_byte(pos, it.data_byte);
      bit_count += 64'd8;
      if (pos == 6'd63) sha0_compress();
    end
    if (it.end_of_message) begin
      pos = bit_count[8:3];
      place_msg_byte(pos, PAD_MARK);
      for (int i = pos[5:2] + 1; i < 16; i++) msg_block[i] = '0;
      if (pos >= 6'd56) begin
        sha0_compress();
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        extra_pad_blocks++;
      end
      msg_block[14] = bit_count[63:32];
      msg_block[15] = bit_count[31:0];
      sha0_compress();
      for (int i = 0; i < 5; i++) begin
        digest_words_due.push_back({
          typed.known ? typed.digest[159 - 32*i -: 32] : hash_state[i],
          3'(i), (i == 4) ? 1'b1 : 1'b0});
      end
      for (int i = 0; i < 5; i++) hash_state[i] = HASH_START[i];
      bit_count = '0;
      messages_done++;
    end else if (!it.byte_present) begin
      idle_count++;
    end
  endfunction

  // Track accepted input transfers
  always @(posedge clk) begin : in_monitor
    digest_ref_t ref_entry;
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) hash_state[i] = HASH_START[i];
      bit_count = '0;
    end else if (in_valid && !in_stall) begin
      ref_entry = '0;
      if (typed_digests.size() != 0) ref_entry = typed_digests.pop_front();
      sha0_absorb(in_data, ref_entry);
    end
  end

  // Check each digest word transfer against the oldest expectation
  always @(posedge clk) begin : out_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_words_due.size() == 0) begin
        $error("unexpected digest word %08h (word_number %0d)",
               out_data.digest_word, out_data.word_number);
        failures++;
      end else begin
        want = digest_words_due.pop_front();
        words_checked++;
        if (out_data.digest_word !== want.digest_word) begin
          $error("digest_word: expected %08h, got %08h", want.digest_word,
                 out_data.digest_word);
          failures++;
        end
        if (out_data.word_number !== want.word_number) begin
          $error("word_number: expected %0d, got %0d", want.word_number,
                 out_data.word_number);
          failures++;
        end
        if (out_data.last_word !== want.last_word) begin
          $error("last_word: expected %0b, got %0b", want.last_word,
                 out_data.last_word);
          failures++;
        end
      end
    end
  end

  // Randomly stall the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sha0_hash_engine: errors");
    $finish;
  end

  // Present one transfer, with random idle cycles ahead of it, and hold until taken
  task automatic send_item(input in_item_t it, input logic known, input logic [159:0] digest);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_digests.push_back({known, digest});
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.byte_present || it.end_of_message) item_count++;
  endtask

  // Drop valid and hold off until every digest word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_words_due.size() != 0) @(posedge clk);
  endtask

  // Mostly short messages, some around the padding boundary, a few near two blocks
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(8);
    if (r < 80) return $urandom_range(50, 9);
    if (r < 95) return $urandom_range(66, 52);
    return $urandom_range(130, 110);
  endfunction

  task automatic send_message(input int len, input logic end_on_byte);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        it = {8'($urandom_range(255)), 1'b0, 1'b0};
        send_item(it, 1'b0, '0);
      end
      it = {8'($urandom_range(255)), 1'b1, (end_on_byte && i == len - 1)};
      send_item(it, 1'b0, '0);
    end
    if (!(end_on_byte && len > 0)) begin
      it = {8'($urandom_range(255)), 1'b0, 1'b1};
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int phase_start;
    // Directed rows: data, present, end, typed digest flag, digest
    directed_rows.push_back({8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST});
    directed_rows.push_back({8'h61, 1'b1, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'h62, 1'b1, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST});
    directed_rows.push_back({8'hFF, 1'b0, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'hAA, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST});
    directed_rows.push_back({8'h00, 1'b1, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'h55, 1'b0, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'hFF, 1'b1, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'h80, 1'b1, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'h7F, 1'b1, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'h01, 1'b1, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'hFE, 1'b0, 1'b1, 1'b0, 160'h0});
    directed_rows.push_back({8'hFF, 1'b1, 1'b1, 1'b0, 160'h0});
    directed_rows.push_back({8'h00, 1'b1, 1'b1, 1'b0, 160'h0});
    directed_rows.push_back({8'h00, 1'b0, 1'b0, 1'b0, 160'h0});
    directed_rows.push_back({8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_item({directed_rows[i].data_byte, directed_rows[i].byte_present,
                 directed_rows[i].end_of_message},
                directed_rows[i].known, directed_rows[i].digest);
    end
    drain();

    // Random messages in three idle/stall phases, pausing between them
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 7;
          recv_stall_pct = 62;
        end
        1: begin
          sender_idle_pct = 62;
          recv_stall_pct = 7;
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_start = item_count;
      while (item_count - phase_start < PhaseItems)
        send_message(pick_length(), 1'($urandom_range(1)));
      drain();
    end

    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d message transfers and %0d idle transfers over %0d messages,",
             item_count, idle_count, messages_done);
    $display("%0d needing an extra padding block; %0d digest words checked.",
             extra_pad_blocks, words_checked);
    if (failures == 0) begin
      $display("tb_sha0_hash_engine: clean");
    end else begin
      $display("tb_sha0_hash_engine: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
